// ===== hdl/escaped_frame_receiver_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Escaped frame receiver assertion macros
// Concurrent check helpers used by the receiver top-level RTL.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define EFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("escaped frame receiver check failed");
`define EFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("escaped frame receiver check failed");
`else
`define EFR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define EFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Shared constants, register indexes and beat types.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int MAX_PACKET_DEF = 256;
  localparam int NUM_SLOTS_DEF  = 4;

  localparam logic [1:0] CFG_FLAG_BYTE   = 2'd0;
  localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd1;
  localparam logic [1:0] CFG_ESCAPE_MASK = 2'd2;
  localparam logic [1:0] CFG_MAX_LENGTH  = 2'd3;

  localparam logic [7:0] FLAG_BYTE_RST   = 8'd126;
  localparam logic [7:0] ESCAPE_BYTE_RST = 8'd125;
  localparam logic [7:0] ESCAPE_MASK_RST = 8'd32;
  localparam logic [8:0] MAX_LENGTH_RST  = 9'd256;

  localparam logic EV_PAYLOAD = 1'b0;
  localparam logic EV_DONE    = 1'b1;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] escape_mask;
    logic [8:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
  } in_item_t;

  typedef struct packed {
    logic       event_kind;
    logic [1:0] slot;
    logic [7:0] byte_index;
    logic [7:0] payload_byte;
    logic [8:0] packet_length;
  } result_t;

endpackage

// ===== hdl/efr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver configuration registers
// Holds flag, escape, mask and length limit written through the config port.
// ----------------------------------------------------------------------------
module efr_cfg_regs
  import efr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_byte   <= FLAG_BYTE_RST;
      cfg.escape_byte <= ESCAPE_BYTE_RST;
      cfg.escape_mask <= ESCAPE_MASK_RST;
      cfg.max_length  <= MAX_LENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FLAG_BYTE:   cfg.flag_byte   <= cfg_data[7:0];
        CFG_ESCAPE_BYTE: cfg.escape_byte <= cfg_data[7:0];
        CFG_ESCAPE_MASK: cfg.escape_mask <= cfg_data[7:0];
        CFG_MAX_LENGTH:  cfg.max_length  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/efr_in_stage.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver input stage
// Registers one received beat and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module efr_in_stage
  import efr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== hdl/efr_core.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver core
// Deframing state and the single-pass decode of one byte into a result.
// ----------------------------------------------------------------------------
module efr_core
  import efr_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF,
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  in_item_t item,
  input  logic     advance,
  output logic     emit,
  output result_t  res
);

  localparam int CW = $clog2(MAX_PACKET + 1);
  localparam int LW = (CW > 9) ? CW : 9;
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_IN   = 2'd1,
    MODE_ESC  = 2'd2
  } mode_t;

  mode_t          rx_mode, rx_mode_next, mode_eff;
  logic [CW-1:0]  frame_count, frame_count_next, count_eff;
  logic [SW-1:0]  current_slot, current_slot_next;
  logic [LW-1:0]  limit;
  logic           over;

  always_comb begin
    limit = (LW'(cfg.max_length) < LW'(MAX_PACKET)) ? LW'(cfg.max_length)
                                                    : LW'(MAX_PACKET);
    over      = LW'(frame_count) >= limit;
    mode_eff  = over ? MODE_HUNT : rx_mode;
    count_eff = over ? '0 : frame_count;

    rx_mode_next      = MODE_HUNT;
    frame_count_next  = count_eff;
    current_slot_next = current_slot;
    emit              = 1'b0;
    res.event_kind    = EV_PAYLOAD;
    res.slot          = 2'(current_slot);
    res.byte_index    = 8'(count_eff);
    res.payload_byte  = item.rx_byte;
    res.packet_length = '0;

    case (mode_eff)
      MODE_ESC: begin
        emit             = 1'b1;
        res.payload_byte = item.rx_byte ^ cfg.escape_mask;
        frame_count_next = count_eff + CW'(1);
        rx_mode_next     = MODE_IN;
      end
      MODE_IN: begin
        if (item.rx_byte == cfg.escape_byte) begin
          rx_mode_next = MODE_ESC;
        end else if (item.rx_byte == cfg.flag_byte) begin
          if (count_eff == '0) begin
            rx_mode_next = MODE_IN;
          end else begin
            emit              = 1'b1;
            res.event_kind    = EV_DONE;
            res.byte_index    = '0;
            res.payload_byte  = '0;
            res.packet_length = 9'(count_eff);
            rx_mode_next      = MODE_HUNT;
            frame_count_next  = '0;
            current_slot_next = (32'(current_slot) == NUM_SLOTS - 1) ? '0
                                : current_slot + SW'(1);
          end
        end else begin
          emit             = 1'b1;
          frame_count_next = count_eff + CW'(1);
          rx_mode_next     = MODE_IN;
        end
      end
      default: begin
        if (item.rx_byte == cfg.flag_byte) begin
          rx_mode_next     = MODE_IN;
          frame_count_next = '0;
        end
      end
    endcase

    if (item.line_error) begin
      emit              = 1'b0;
      rx_mode_next      = rx_mode;
      frame_count_next  = frame_count;
      current_slot_next = current_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode      <= MODE_HUNT;
      frame_count  <= '0;
      current_slot <= '0;
    end else if (advance) begin
      rx_mode      <= rx_mode_next;
      frame_count  <= frame_count_next;
      current_slot <= current_slot_next;
    end
  end

endmodule

// ===== hdl/efr_out_stage.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver output stage
// Result register that presents one beat on the master side.
// ----------------------------------------------------------------------------
module efr_out_stage
  import efr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    can_take,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_res <= res;
    end
  end

endmodule

// ===== hdl/escaped_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// Escaped frame receiver unit
// Removes flag framing and escape stuffing from received serial bytes.
//
//   Channel   Dir  Payload
//   s_*       in   tdata: rx_byte; tuser: line_error
//   m_*       out  tdata: slot, byte_index, payload_byte, packet_length;
//                  tuser: event_kind
//   cfg_*     in   cfg_index: register, cfg_data: value
//
// One byte is taken every cycle unless the master side stalls, a rate set by
// the core's single-pass update. Input and output stages each register a beat.
// Reset clears mode, count, slot and both stage valid flags.
// A stalled master side holds its beat and stops the input stage behind it.
// ----------------------------------------------------------------------------
`include "escaped_frame_receiver_unit_macros.svh"

module escaped_frame_receiver_unit
  import efr_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF,
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] line_error
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [1:0] slot, [9:2] byte_index,
                                 // [17:10] payload_byte, [26:18] packet_length
  output logic        m_tuser,   // [0] event_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  cfg_t     cfg;
  in_item_t in_item, item;
  logic     item_valid, advance, can_take, emit;
  result_t  res, out_res;

  assign cfg_ready = 1'b1;
  assign in_item.rx_byte    = s_tdata;
  assign in_item.line_error = s_tuser;
  assign advance = item_valid && can_take;

  efr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  efr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  efr_core #(
    .MAX_PACKET (MAX_PACKET),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (item),
    .advance (advance),
    .emit    (emit),
    .res     (res)
  );

  efr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .res       (res),
    .can_take  (can_take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tuser = out_res.event_kind;
  assign m_tdata = {5'd0, out_res.packet_length, out_res.payload_byte,
                    out_res.byte_index, out_res.slot};

  `EFR_ASSERT_IMPL(a_done_nonempty, clk, rst, m_tvalid && m_tuser, m_tdata[26:18] != 9'd0)
  `EFR_ASSERT_IMPL(a_payload_nolen, clk, rst, m_tvalid && !m_tuser, m_tdata[26:18] == 9'd0)
  `EFR_ASSERT_IMPL(a_slot_range, clk, rst, m_tvalid, 32'(m_tdata[1:0]) < NUM_SLOTS)
  `EFR_ASSERT_NEXT(a_empty_ready, clk, rst, !m_tvalid && !item_valid, s_tready)

endmodule

// ===== test/efr_result_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped frame receiver result checker
// Watches the byte input, result and register write channels of the
// receiver. Every accepted input beat runs through a cycle-free model of the
// deframer, and the result it should produce is queued. Every result beat is
// compared field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module efr_result_check
  import efr_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF,
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          events_seen
);

  typedef enum logic [1:0] {
    HUNTING  = 2'd0,
    IN_FRAME = 2'd1,
    ESCAPED  = 2'd2
  } rx_mode_t;

  cfg_t     regs;
  rx_mode_t mode;
  int       frame_len;
  int       slot_no;
  result_t  expected_events[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    events_seen = 0;
  end

  function automatic bit deframe_byte(input logic [7:0] b, input logic err,
                                      output result_t r);
    int lim;
    r = '0;
    if (err) begin
      return 1'b0;
    end
    lim = (int'(regs.max_length) > MAX_PACKET) ? MAX_PACKET : int'(regs.max_length);
    if (frame_len >= lim) begin
      mode      = HUNTING;
      frame_len = 0;
    end
    r.slot = slot_no[1:0];
    case (mode)
      ESCAPED: begin
        r.event_kind   = EV_PAYLOAD;
        r.byte_index   = frame_len[7:0];
        r.payload_byte = b ^ regs.escape_mask;
        frame_len++;
        mode = IN_FRAME;
        return 1'b1;
      end
      IN_FRAME: begin
        if (b == regs.escape_byte) begin
          mode = ESCAPED;
          return 1'b0;
        end
        if (b == regs.flag_byte) begin
          if (frame_len == 0) begin
            return 1'b0;
          end
          r.event_kind    = EV_DONE;
          r.packet_length = frame_len[8:0];
          mode      = HUNTING;
          frame_len = 0;
          slot_no   = (slot_no + 1) % NUM_SLOTS;
          return 1'b1;
        end
        r.event_kind   = EV_PAYLOAD;
        r.byte_index   = frame_len[7:0];
        r.payload_byte = b;
        frame_len++;
        return 1'b1;
      end
      default: begin
        if (b == regs.flag_byte) begin
          mode      = IN_FRAME;
          frame_len = 0;
        end else begin
          mode = HUNTING;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t predicted;
    if (rst) begin
      regs.flag_byte   = FLAG_BYTE_RST;
      regs.escape_byte = ESCAPE_BYTE_RST;
      regs.escape_mask = ESCAPE_MASK_RST;
      regs.max_length  = MAX_LENGTH_RST;
      mode      = HUNTING;
      frame_len = 0;
      slot_no   = 0;
      expected_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FLAG_BYTE:   regs.flag_byte   = cfg_data[7:0];
          CFG_ESCAPE_BYTE: regs.escape_byte = cfg_data[7:0];
          CFG_ESCAPE_MASK: regs.escape_mask = cfg_data[7:0];
          CFG_MAX_LENGTH:  regs.max_length  = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        events_seen++;
        if (expected_events.size() == 0) begin
          $display("%0t ns: result beat expected none, got kind %0d tdata %h",
                   $time, m_tuser, m_tdata);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          compare_field("event_kind", 32'(want.event_kind), 32'(m_tuser));
          compare_field("slot", 32'(want.slot), 32'(m_tdata[1:0]));
          compare_field("byte_index", 32'(want.byte_index), 32'(m_tdata[9:2]));
          compare_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[17:10]));
          compare_field("packet_length", 32'(want.packet_length), 32'(m_tdata[26:18]));
          compare_field("tdata padding", 32'd0, 32'(m_tdata[31:27]));
        end
      end
      if (s_tvalid && s_tready) begin
        if (deframe_byte(s_tdata, s_tuser, predicted)) begin
          expected_events.push_back(predicted);
        end
      end
    end
    outstanding = expected_events.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped frame receiver testbench
// Drives received bytes into the receiver: a short directed sequence over
// escapes, empty-frame flags, line errors and length limits, then random
// stuffed frames mixed with noise under a series of register settings.
// Both stream sides idle at random, and the result side holds off once for a
// long stretch. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import efr_pkg::*;

  localparam int MAX_PACKET = MAX_PACKET_DEF;
  localparam int NUM_SLOTS  = NUM_SLOTS_DEF;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [8:0]  cfg_data  = 9'd0;

  int mismatches;
  int outstanding;
  int events_seen;

  cfg_t cur;
  int   lim;
  int   beats_sent;
  int   settings_loaded;
  int   sender_idle;
  int   receiver_idle;
  bit   hold_off_req;

  escaped_frame_receiver_unit #(
    .MAX_PACKET(MAX_PACKET),
    .NUM_SLOTS (NUM_SLOTS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  efr_result_check #(
    .MAX_PACKET(MAX_PACKET),
    .NUM_SLOTS (NUM_SLOTS)
  ) result_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .events_seen(events_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off_req = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= receiver_idle);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic err);
    while ($urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= err;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic apply_setting(input cfg_t s);
    logic [1:0] idx[4];
    logic [8:0] val[4];
    idx = '{CFG_FLAG_BYTE, CFG_ESCAPE_BYTE, CFG_ESCAPE_MASK, CFG_MAX_LENGTH};
    val = '{{1'b0, s.flag_byte}, {1'b0, s.escape_byte}, {1'b0, s.escape_mask},
            s.max_length};
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur = s;
    lim = (int'(s.max_length) > MAX_PACKET) ? MAX_PACKET : int'(s.max_length);
    settings_loaded++;
  endtask

  task automatic send_frame(input int len);
    logic [7:0] v;
    int         pick;
    send_beat(cur.flag_byte, 1'b0);
    if ($urandom_range(9) == 0) send_beat(cur.flag_byte, 1'b0);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(9);
      if (pick == 0) v = cur.flag_byte;
      else if (pick == 1) v = cur.escape_byte;
      else v = 8'($urandom_range(255));
      if ($urandom_range(29) == 0) send_beat(8'($urandom_range(255)), 1'b1);
      if (v == cur.flag_byte || v == cur.escape_byte || $urandom_range(9) == 0) begin
        send_beat(cur.escape_byte, 1'b0);
        send_beat(v ^ cur.escape_mask, 1'b0);
      end else begin
        send_beat(v, 1'b0);
      end
    end
    send_beat(cur.flag_byte, 1'b0);
  endtask

  task automatic send_noise();
    int n;
    case ($urandom_range(2))
      0: begin
        n = $urandom_range(1, 6);
        repeat (n) send_beat(8'($urandom_range(255)), $urandom_range(4) == 0);
      end
      1: begin
        send_beat(cur.flag_byte, 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) send_beat(8'($urandom_range(255)), 1'b0);
      end
      default: begin
        send_beat(cur.flag_byte, 1'b0);
        send_beat(cur.escape_byte, 1'b0);
        send_beat(cur.flag_byte, 1'b0);
        send_beat(cur.flag_byte, 1'b0);
      end
    endcase
  endtask

  initial begin
    cfg_t s;
    int   budget;
    int   start;
    int   random_start;
    int   rs;
    int   len;
    int   r;
    int   w;
    bit   pressure_done;
    beats_sent      = 0;
    settings_loaded = 0;
    sender_idle     = 34;
    receiver_idle   = 87;
    hold_off_req    = 1'b0;
    pressure_done   = 1'b0;
    cur = '{FLAG_BYTE_RST, ESCAPE_BYTE_RST, ESCAPE_MASK_RST, MAX_LENGTH_RST};
    lim = MAX_PACKET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(8'h7E, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h7E, 1'b0);
    send_beat(8'h7E, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h7D, 1'b0);
    send_beat(8'h5E, 1'b0);
    send_beat(8'h7D, 1'b0);
    send_beat(8'h7E, 1'b0);
    send_beat(8'h7D, 1'b0);
    send_beat(8'h7D, 1'b0);
    send_beat(8'h7E, 1'b1);
    send_beat(8'h7D, 1'b0);
    send_beat(8'h7E, 1'b1);
    send_beat(8'h20, 1'b0);
    send_beat(8'h7E, 1'b0);
    send_beat(8'h41, 1'b0);
    send_beat(8'h7E, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'h7E, 1'b0);

    apply_setting('{8'h7E, 8'h7D, 8'h20, 9'd2});
    send_beat(8'h7E, 1'b0);
    send_beat(8'h11, 1'b0);
    send_beat(8'h22, 1'b0);
    send_beat(8'h7E, 1'b0);
    send_beat(8'h33, 1'b0);
    send_beat(8'h7E, 1'b0);
    apply_setting('{8'h7E, 8'h7D, 8'h20, 9'd0});
    send_beat(8'h7E, 1'b0);
    send_beat(8'h44, 1'b0);

    random_start = beats_sent;
    for (int p = 0; p < 10; p++) begin
      budget = 100;
      case (p)
        0: s = '{8'h7E, 8'h7D, 8'h20, 9'd256};
        1: s = '{8'h00, 8'hFF, 8'hFF, 9'd1};
        2: s = '{8'hFF, 8'h00, 8'h00, 9'd511};
        4: s = '{8'hC0, 8'hDB, 8'h5A, 9'd256};
        5: s = '{8'h55, 8'h55, 8'hAA, 9'd20};
        6: begin
          s = '{8'h7E, 8'h7D, 8'h20, 9'd0};
          budget = 40;
        end
        8: begin
          s.escape_byte = 8'($urandom_range(255));
          do s.flag_byte = 8'($urandom_range(255)); while (s.flag_byte == s.escape_byte);
          s.escape_mask = 8'($urandom_range(255));
          s.max_length  = 9'd257;
        end
        9: s = '{FLAG_BYTE_RST, ESCAPE_BYTE_RST, ESCAPE_MASK_RST, MAX_LENGTH_RST};
        default: begin
          s.escape_byte = 8'($urandom_range(255));
          do s.flag_byte = 8'($urandom_range(255)); while (s.flag_byte == s.escape_byte);
          s.escape_mask = 8'($urandom_range(255));
          s.max_length  = (p == 3) ? 9'($urandom_range(2, 40))
                                   : 9'($urandom_range(1, 300));
        end
      endcase
      apply_setting(s);
      start = beats_sent;
      if (lim <= 64 || p == 4) send_frame(lim + 1);
      while (beats_sent - start < budget) begin
        rs = beats_sent - random_start;
        if (rs < 480) begin
          sender_idle   = 34;
          receiver_idle = 87;
        end else if (rs < 960) begin
          sender_idle   = 87;
          receiver_idle = 34;
        end else begin
          sender_idle   = 0;
          receiver_idle = 0;
          if (!pressure_done) begin
            hold_off_req  = 1'b1;
            pressure_done = 1'b1;
          end
        end
        if ($urandom_range(99) < 85) begin
          r = $urandom_range(99);
          if (r < 75) len = $urandom_range(0, 8);
          else if (r < 95) len = $urandom_range(0, 24);
          else len = $urandom_range(0, lim + 1);
          send_frame(len);
        end else begin
          send_noise();
        end
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    w = 0;
    while (outstanding != 0 && w < 200000) begin
      @(posedge clk);
      w++;
    end
    repeat (10) @(posedge clk);
    if (outstanding != 0) begin
      $display("tb: %0d expected results never arrived", outstanding);
    end
    $display("Run covered %0d input beats under %0d register settings.",
             beats_sent, settings_loaded);
    $display("%0d result beats checked over escapes, empty flags, line errors and stalls.",
             events_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
